### hdl/fsta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsta_pkg
// shared widths, defaults, register indexes and control structs for the
// fixed step tick accumulator
// ----------------------------------------------------------------------------
package fsta_pkg;

    localparam int TIME_WIDTH     = 32;
    localparam int ACC_WIDTH      = TIME_WIDTH + 1;
    localparam int STEP_WIDTH     = 20;
    localparam int LIMIT_WIDTH    = 6;
    localparam int COUNT_WIDTH    = 64;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int IN_DATA_WIDTH  = 32;
    localparam int OUT_PAYLOAD    = 2 * LIMIT_WIDTH + 2 * COUNT_WIDTH + ACC_WIDTH;
    localparam int OUT_DATA_WIDTH = ((OUT_PAYLOAD + 7) / 8) * 8;
    localparam int DIV_CNT_WIDTH  = $clog2(ACC_WIDTH);

    localparam logic [LIMIT_WIDTH-1:0]   STEP_LIMIT    = LIMIT_WIDTH'(63);
    localparam logic [STEP_WIDTH-1:0]    DEFAULT_STEP  = STEP_WIDTH'(33333);
    localparam logic [LIMIT_WIDTH-1:0]   DEFAULT_LIMIT = LIMIT_WIDTH'(1);
    localparam logic [TIME_WIDTH-1:0]    DEFAULT_CLAMP = TIME_WIDTH'(250000);
    localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST      = DIV_CNT_WIDTH'(ACC_WIDTH - 1);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_TICKS      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_STEPS       = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_FRAME_TICKS = 2'd2;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic capture;
        logic clear;
        logic add;
        logic step_sub;
        logic div_start;
        logic div_iter;
        logic div_commit;
        logic load_tick;
        logic load_status;
    } fsta_cmd_t;

    typedef struct packed {
        logic acc_ge_step;
        logic below_limit;
        logic div_last;
        logic out_free;
    } fsta_stat_t;

endpackage

### hdl/fsta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsta_ctrl
// sequencer per frame: clear or add, step ticks, drop by division, status
// ----------------------------------------------------------------------------
module fsta_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    input  fsta_pkg::fsta_stat_t stat,
    output fsta_pkg::fsta_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD,
        ST_LOOP,
        ST_TICK,
        ST_DIV,
        ST_COMMIT,
        ST_STATUS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == fsta_pkg::OP_CLEAR) ? ST_CLEAR : ST_ADD;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_STATUS;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (stat.acc_ge_step && stat.below_limit)
                begin
                    cmd.step_sub = 1'b1;
                    state_next   = ST_TICK;
                end
                else if (stat.acc_ge_step)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_TICK:
            begin
                if (stat.out_free)
                begin
                    cmd.load_tick = 1'b1;
                    state_next    = ST_LOOP;
                end
            end
            ST_DIV:
            begin
                cmd.div_iter = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.div_commit = 1'b1;
                state_next     = ST_STATUS;
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/fsta_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsta_dp
// accumulator, counters, settings, restoring divider and output register
// ----------------------------------------------------------------------------
module fsta_dp
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fsta_pkg::fsta_cmd_t                     cmd,
    output fsta_pkg::fsta_stat_t                    stat,
    input  logic [fsta_pkg::IN_DATA_WIDTH-1:0]      in_frame,
    input  logic                                    cfg_write,
    input  logic [fsta_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [fsta_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [fsta_pkg::OUT_DATA_WIDTH-1:0]     out_data,
    output logic                                    out_user,
    output logic                                    out_last
);

    localparam int AW = fsta_pkg::ACC_WIDTH;
    localparam int SW = fsta_pkg::STEP_WIDTH;
    localparam int LW = fsta_pkg::LIMIT_WIDTH;
    localparam int CW = fsta_pkg::COUNT_WIDTH;
    localparam int TW = fsta_pkg::TIME_WIDTH;

    logic [SW-1:0] step_cfg_reg;
    logic [LW-1:0] limit_cfg_reg;
    logic [TW-1:0] clamp_cfg_reg;

    logic [AW-1:0] acc_reg;
    logic [AW-1:0] acc_next;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] total_next;
    logic [CW-1:0] dropped_reg;
    logic [CW-1:0] dropped_next;
    logic [LW-1:0] exec_reg;
    logic [LW-1:0] exec_next;

    logic [TW-1:0] frame_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] rem_next;
    logic [AW-1:0] quot_reg;
    logic [AW-1:0] quot_next;
    logic [fsta_pkg::DIV_CNT_WIDTH-1:0] div_cnt_reg;

    logic                              out_valid_reg;
    logic [fsta_pkg::OUT_DATA_WIDTH-1:0] out_data_reg;
    logic                              out_user_reg;
    logic                              out_last_reg;

    logic [SW-1:0] step_eff;
    logic [LW-1:0] limit_eff;
    logic [TW-1:0] clamp_eff;
    logic [TW-1:0] frame_in;
    logic [SW:0]   trial;

    // effective settings, zero values fall back to defaults
    always_comb
    begin
        step_eff  = (step_cfg_reg == '0) ? fsta_pkg::DEFAULT_STEP : step_cfg_reg;
        limit_eff = (limit_cfg_reg == '0) ? fsta_pkg::DEFAULT_LIMIT : limit_cfg_reg;
        if (limit_eff > fsta_pkg::STEP_LIMIT)
        begin
            limit_eff = fsta_pkg::STEP_LIMIT;
        end
        clamp_eff = (clamp_cfg_reg == '0) ? fsta_pkg::DEFAULT_CLAMP : clamp_cfg_reg;
        frame_in  = TW'(in_frame);
    end

    assign stat.acc_ge_step = (acc_reg >= AW'(step_eff));
    assign stat.below_limit = (exec_reg < limit_eff);
    assign stat.div_last    = (div_cnt_reg == fsta_pkg::DIV_LAST);
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign trial = {rem_reg, quot_reg[AW-1]};

    always_comb
    begin
        if (trial >= {1'b0, step_eff})
        begin
            rem_next  = SW'(trial - {1'b0, step_eff});
            quot_next = {quot_reg[AW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = trial[SW-1:0];
            quot_next = {quot_reg[AW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        acc_next     = acc_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        exec_next    = exec_reg;
        if (cmd.capture)
        begin
            exec_next = '0;
        end
        if (cmd.clear)
        begin
            acc_next     = '0;
            total_next   = '0;
            dropped_next = '0;
        end
        if (cmd.add)
        begin
            acc_next = acc_reg + AW'(frame_reg);
        end
        if (cmd.step_sub)
        begin
            acc_next   = acc_reg - AW'(step_eff);
            total_next = total_reg + CW'(1);
        end
        if (cmd.div_commit)
        begin
            acc_next     = AW'(rem_reg);
            dropped_next = dropped_reg + CW'(quot_reg);
        end
        if (cmd.load_tick)
        begin
            exec_next = exec_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg  <= fsta_pkg::DEFAULT_STEP;
            limit_cfg_reg <= fsta_pkg::DEFAULT_LIMIT;
            clamp_cfg_reg <= fsta_pkg::DEFAULT_CLAMP;
            acc_reg       <= '0;
            total_reg     <= '0;
            dropped_reg   <= '0;
            exec_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fsta_pkg::CFG_STEP_TICKS:      step_cfg_reg  <= cfg_data[SW-1:0];
                    fsta_pkg::CFG_MAX_STEPS:       limit_cfg_reg <= cfg_data[LW-1:0];
                    fsta_pkg::CFG_MAX_FRAME_TICKS: clamp_cfg_reg <= cfg_data[TW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            acc_reg     <= acc_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
            exec_reg    <= exec_next;
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_iter)
            begin
                div_cnt_reg <= div_cnt_reg + fsta_pkg::DIV_CNT_WIDTH'(1);
            end
            if (cmd.load_tick || cmd.load_status)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            frame_reg <= (frame_in > clamp_eff) ? clamp_eff : frame_in;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quot_reg <= acc_reg;
        end
        else if (cmd.div_iter)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        if (cmd.load_tick)
        begin
            out_data_reg <= fsta_pkg::OUT_DATA_WIDTH'({acc_reg, dropped_reg, total_reg,
                                                      {LW{1'b0}}, exec_reg});
            out_user_reg <= fsta_pkg::KIND_TICK;
            out_last_reg <= 1'b0;
        end
        else if (cmd.load_status)
        begin
            out_data_reg <= fsta_pkg::OUT_DATA_WIDTH'({acc_reg, dropped_reg, total_reg,
                                                      exec_reg, {LW{1'b0}}});
            out_user_reg <= fsta_pkg::KIND_STATUS;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

### hdl/fixed_step_tick_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_step_tick_accumulator
// flow: capture the input, add the clamped frame, one tick result per whole
//   step up to the step limit, remaining whole steps dropped by the divider
//   (one quotient bit a cycle), then the status result; a clear goes to status
// reset: accumulator and counters cleared, settings at their defaults
// ----------------------------------------------------------------------------
module fixed_step_tick_accumulator
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [fsta_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [fsta_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // frame_ticks
    input  logic [fsta_pkg::IN_DATA_WIDTH-1:0]      s_axis_tdata,
    // op
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // step_index, executed_count, total_count, dropped_count, residual_ticks
    output logic [fsta_pkg::OUT_DATA_WIDTH-1:0]     m_axis_tdata,
    // kind
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);

    fsta_pkg::fsta_cmd_t  cmd;
    fsta_pkg::fsta_stat_t stat;

    assign cfg_ready = 1'b1;

    fsta_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fsta_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_frame  (s_axis_tdata),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
